FILE: design/alist_pkg.sv
// Shared types and constants for the array list block.
// Used by alist_ram, array_list_insert_delete_search and the bench files; no dependencies.
package alist_pkg;

  // Store geometry
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Command item
  typedef struct packed {
    cmd_t                      cmd;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  item_value;
  } req_t;

  // Result item
  typedef struct packed {
    status_t                   status;
    logic [POS_W-1:0]          found_position;
    logic signed [DATA_W-1:0]  read_value;
    logic [POS_W-1:0]          list_length;
  } rsp_t;

endpackage

FILE: design/alist_ram.sv
// Element store: one write port, one read port, registered read data.
// Depends on alist_pkg for depth and word width.
module alist_ram (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [alist_pkg::ADDR_W-1:0]             waddr,
  input  logic signed [alist_pkg::DATA_W-1:0]      wdata,
  input  logic [alist_pkg::ADDR_W-1:0]             raddr,
  output logic signed [alist_pkg::DATA_W-1:0]      rdata
);

  logic signed [alist_pkg::DATA_W-1:0] mem [alist_pkg::CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/array_list_insert_delete_search.sv
// Array list of signed words with 1-based positions, held in one 1R1W memory.
// The walk moves one entry per cycle through the single memory read port. One item
// is in work at a time, so a new item is accepted only once the last one has been
// handed to the output register; a finished item may wait in that register.
// Reset (rst, synchronous) empties the list.
module array_list_insert_delete_search (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  alist_pkg::req_t    req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output alist_pkg::rsp_t    rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_SHIFT,
    S_FIND,
    S_RD,
    S_RD_DATA,
    S_EMIT
  } state_t;

  state_t                                   state;
  logic [alist_pkg::ADDR_W-1:0]             ra;
  logic [alist_pkg::ADDR_W-1:0]             rd_last;
  logic                                     pend;
  logic [alist_pkg::CNT_W-1:0]              count;
  logic [alist_pkg::POS_W-1:0]              pos_q;
  logic signed [alist_pkg::DATA_W-1:0]      val_q;
  alist_pkg::rsp_t                          res;

  logic                                     we;
  logic [alist_pkg::ADDR_W-1:0]             waddr;
  logic signed [alist_pkg::DATA_W-1:0]      wdata;
  logic signed [alist_pkg::DATA_W-1:0]      rdata;

  logic [alist_pkg::CNT_W:0]                count_ext;
  logic [alist_pkg::CNT_W:0]                pos_ext;
  logic                                     bad_pos;
  logic                                     bad_ins_pos;
  logic [alist_pkg::ADDR_W-1:0]             pos_addr;
  logic [alist_pkg::ADDR_W-1:0]             last_addr;

  alist_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra),
    .rdata (rdata)
  );

  assign req_ready = (state == S_IDLE);

  // position checks on the incoming item
  assign count_ext   = {1'b0, count};
  assign pos_ext     = (alist_pkg::CNT_W + 1)'(req.position);
  assign bad_pos     = (req.position == '0) || (pos_ext > count_ext);
  assign bad_ins_pos = (req.position == '0) ||
                       (pos_ext > count_ext + (alist_pkg::CNT_W + 1)'(1));

  // addresses of the held item
  assign pos_addr  = alist_pkg::ADDR_W'(pos_q - alist_pkg::POS_W'(1));
  assign last_addr = alist_pkg::ADDR_W'(count - alist_pkg::CNT_W'(1));

  // write back: shifted word lands one slot past (insert) or before (delete); insert then writes the new word
  always_comb begin
    we    = 1'b0;
    waddr = rd_last;
    wdata = rdata;
    unique case (state)
      S_INS_SHIFT: begin
        we    = pend;
        waddr = rd_last + alist_pkg::ADDR_W'(1);
      end
      S_INS_PUT: begin
        we    = 1'b1;
        waddr = pos_addr;
        wdata = val_q;
      end
      S_DEL_SHIFT: begin
        we    = pend;
        waddr = rd_last - alist_pkg::ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  // sequencer, length counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            pos_q                  <= req.position;
            val_q                  <= req.item_value;
            pend                   <= 1'b0;
            res.found_position     <= '0;
            res.read_value         <= '0;
            unique case (req.cmd)
              alist_pkg::CMD_INSERT: begin
                res.list_length <= alist_pkg::POS_W'(count);
                if (count >= alist_pkg::CNT_W'(alist_pkg::CAPACITY)) begin
                  res.status <= alist_pkg::ST_FULL;
                  state      <= S_EMIT;
                end else if (bad_ins_pos) begin
                  res.status <= alist_pkg::ST_BAD_POS;
                  state      <= S_EMIT;
                end else if (pos_ext == count_ext + (alist_pkg::CNT_W + 1)'(1)) begin
                  res.status <= alist_pkg::ST_OK;
                  state      <= S_INS_PUT;
                end else begin
                  res.status <= alist_pkg::ST_OK;
                  ra         <= alist_pkg::ADDR_W'(count - alist_pkg::CNT_W'(1));
                  state      <= S_INS_SHIFT;
                end
              end
              alist_pkg::CMD_DELETE: begin
                if (bad_pos) begin
                  res.status      <= alist_pkg::ST_BAD_POS;
                  res.list_length <= alist_pkg::POS_W'(count);
                  state           <= S_EMIT;
                end else if (pos_ext == count_ext) begin
                  // last element: nothing to move
                  res.status      <= alist_pkg::ST_OK;
                  count           <= count - alist_pkg::CNT_W'(1);
                  res.list_length <= alist_pkg::POS_W'(count - alist_pkg::CNT_W'(1));
                  state           <= S_EMIT;
                end else begin
                  res.status      <= alist_pkg::ST_OK;
                  res.list_length <= alist_pkg::POS_W'(count);
                  ra              <= alist_pkg::ADDR_W'(req.position);
                  state           <= S_DEL_SHIFT;
                end
              end
              alist_pkg::CMD_FIND: begin
                res.list_length <= alist_pkg::POS_W'(count);
                if (count == '0) begin
                  res.status <= alist_pkg::ST_NOT_FOUND;
                  state      <= S_EMIT;
                end else begin
                  res.status <= alist_pkg::ST_OK;
                  ra         <= alist_pkg::ADDR_W'(count - alist_pkg::CNT_W'(1));
                  state      <= S_FIND;
                end
              end
              alist_pkg::CMD_READ: begin
                res.list_length <= alist_pkg::POS_W'(count);
                if (bad_pos) begin
                  res.status <= alist_pkg::ST_BAD_POS;
                  state      <= S_EMIT;
                end else begin
                  res.status <= alist_pkg::ST_OK;
                  ra         <= alist_pkg::ADDR_W'(req.position - alist_pkg::POS_W'(1));
                  state      <= S_RD;
                end
              end
            endcase
          end
        end
        // walk down from the top, moving each word up one slot
        S_INS_SHIFT: begin
          if (pend && (rd_last == pos_addr)) begin
            pend  <= 1'b0;
            state <= S_INS_PUT;
          end else begin
            rd_last <= ra;
            ra      <= ra - alist_pkg::ADDR_W'(1);
            pend    <= 1'b1;
          end
        end
        S_INS_PUT: begin
          count           <= count + alist_pkg::CNT_W'(1);
          res.list_length <= alist_pkg::POS_W'(count + alist_pkg::CNT_W'(1));
          state           <= S_EMIT;
        end
        // walk up from the gap, moving each word down one slot
        S_DEL_SHIFT: begin
          if (pend && (rd_last == last_addr)) begin
            pend            <= 1'b0;
            count           <= count - alist_pkg::CNT_W'(1);
            res.list_length <= alist_pkg::POS_W'(count - alist_pkg::CNT_W'(1));
            state           <= S_EMIT;
          end else begin
            rd_last <= ra;
            ra      <= ra + alist_pkg::ADDR_W'(1);
            pend    <= 1'b1;
          end
        end
        // search from the top; first hit is the highest position
        S_FIND: begin
          if (pend && (rdata == val_q)) begin
            pend               <= 1'b0;
            res.found_position <= alist_pkg::POS_W'(rd_last) + alist_pkg::POS_W'(1);
            state              <= S_EMIT;
          end else if (pend && (rd_last == '0)) begin
            pend       <= 1'b0;
            res.status <= alist_pkg::ST_NOT_FOUND;
            state      <= S_EMIT;
          end else begin
            rd_last <= ra;
            ra      <= ra - alist_pkg::ADDR_W'(1);
            pend    <= 1'b1;
          end
        end
        S_RD: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res.read_value <= rdata;
          state          <= S_EMIT;
        end
        // hand the item to the output register once it is free
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // an accepted item always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state != S_IDLE))
    else $error("block idle after accepting an item");

  // the length moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((count == $past(count)) ||
              (count == $past(count) + alist_pkg::CNT_W'(1)) ||
              (count == $past(count) - alist_pkg::CNT_W'(1))))
    else $error("list length jumped");

  // memory is written only while an item is in work
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    we |-> (state != S_IDLE) && (state != S_EMIT))
    else $error("memory write outside an operation");

  // a new result comes only from the emit step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_EMIT))
    else $error("result loaded outside emit");
`endif

endmodule

FILE: bench/array_list_checker.sv
// Result checker for the array list block: mirrors the list, predicts each result.
// Watches the command and result channels; depends on alist_pkg.
module array_list_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_ready,
  input  alist_pkg::req_t req,
  input  logic            rsp_valid,
  input  logic            rsp_ready,
  input  alist_pkg::rsp_t rsp,
  output int              fail_count,
  output int              pending
);
  import alist_pkg::*;

  // Mirror of the list contents and length
  logic signed [DATA_W-1:0] mirror_words [CAPACITY];
  int                       mirror_len;

  rsp_t awaited_rsps [$];
  rsp_t oldest;
  int   mismatches;

  // Apply one command to the mirror and return the result it should produce
  function automatic rsp_t apply_list_cmd(req_t c);
    rsp_t o;
    int   p;
    int   k;
    bit   hit;
    o        = '0;
    o.status = ST_OK;
    p        = int'(c.position);
    hit      = 1'b0;
    case (c.cmd)
      CMD_INSERT: begin
        // fullness wins over a bad position
        if (mirror_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else if (p < 1 || p > mirror_len + 1) begin
          o.status = ST_BAD_POS;
        end else begin
          for (k = mirror_len; k >= p; k--)
            mirror_words[k] = mirror_words[k-1];
          mirror_words[p-1] = c.item_value;
          mirror_len++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > mirror_len) begin
          o.status = ST_BAD_POS;
        end else begin
          for (k = p; k < mirror_len; k++)
            mirror_words[k-1] = mirror_words[k];
          mirror_len--;
        end
      end
      CMD_FIND: begin
        // highest matching position wins
        o.status = ST_NOT_FOUND;
        for (k = mirror_len; k >= 1 && !hit; k--) begin
          if (mirror_words[k-1] == c.item_value) begin
            hit              = 1'b1;
            o.status         = ST_OK;
            o.found_position = POS_W'(k);
          end
        end
      end
      default: begin
        if (p < 1 || p > mirror_len)
          o.status = ST_BAD_POS;
        else
          o.read_value = mirror_words[p-1];
      end
    endcase
    o.list_length = POS_W'(mirror_len);
    return o;
  endfunction

  // Compare results in order, then queue the prediction for a new command
  always @(posedge clk) begin
    if (rst) begin
      mirror_len = 0;
      mismatches = 0;
      awaited_rsps.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected result st=%0d pos=%0d rd=%0d len=%0d",
                     rsp.status, rsp.found_position, rsp.read_value, rsp.list_length);
        end else begin
          oldest = awaited_rsps.pop_front();
          if (oldest.status !== rsp.status || oldest.found_position !== rsp.found_position ||
              oldest.read_value !== rsp.read_value || oldest.list_length !== rsp.list_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d pos=%0d rd=%0d len=%0d, got st=%0d pos=%0d rd=%0d len=%0d",
                       oldest.status, oldest.found_position, oldest.read_value,
                       oldest.list_length, rsp.status, rsp.found_position,
                       rsp.read_value, rsp.list_length);
          end
        end
      end
      if (req_valid && req_ready)
        awaited_rsps.push_back(apply_list_cmd(req));
      fail_count <= mismatches;
      pending    <= awaited_rsps.size();
    end
  end

endmodule

FILE: bench/tb_array_list_insert_delete_search.sv
// Top of the array list testbench: clock, reset, command stimulus, result draining.
// Depends on alist_pkg, array_list_insert_delete_search and array_list_checker.
module tb_array_list_insert_delete_search;
  import alist_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int MAX_GAP      = 18;
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 600000;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   fail_count;
  int   pending;

  // Stimulus-side view of the list length, used to aim positions
  int   len_guess = 0;
  bit   send_burst = 1'b0;

  always #5 clk = ~clk;

  array_list_insert_delete_search dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  array_list_checker results_check (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic req_t list_cmd(cmd_t c, int pos, logic [DATA_W-1:0] v);
    req_t r;
    r.cmd        = c;
    r.position   = POS_W'(pos);
    r.item_value = v;
    return r;
  endfunction

  // Values that repeat often, so finds hit and duplicates occur
  function automatic logic [DATA_W-1:0] pooled_value();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h5555_5555;
      6:       return 32'hAAAA_AAAA;
      default: return 32'h0000_002A;
    endcase
  endfunction

  // Draw a command weighted by phase, mostly at legal positions
  function automatic req_t pick_command(phase_t ph);
    int   roll;
    int   ins_th;
    int   del_th;
    int   find_th;
    int   upper;
    int   pos;
    cmd_t c;
    logic [DATA_W-1:0] v;
    case (ph)
      PH_FILL:  begin ins_th = 70; del_th = 80; find_th = 90; end
      PH_DRAIN: begin ins_th = 10; del_th = 80; find_th = 90; end
      default:  begin ins_th = 30; del_th = 55; find_th = 80; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_th)       c = CMD_INSERT;
    else if (roll < del_th)  c = CMD_DELETE;
    else if (roll < find_th) c = CMD_FIND;
    else                     c = CMD_READ;

    upper = (c == CMD_INSERT) ? len_guess + 1 : len_guess;
    roll  = $urandom_range(0, 99);
    if (upper >= 1 && roll < 85) begin
      if (roll < 10)      pos = 1;
      else if (roll < 20) pos = upper;
      else                pos = $urandom_range(1, upper);
    end else begin
      case ($urandom_range(0, 2))
        0:       pos = 0;
        1:       pos = upper + 1;
        default: pos = $urandom_range(0, 127);
      endcase
    end

    if ($urandom_range(0, 99) < ((c == CMD_FIND) ? 70 : 50))
      v = pooled_value();
    else
      v = $urandom;
    return list_cmd(c, pos, v);
  endfunction

  function automatic void track_length(req_t r);
    int p;
    p = int'(r.position);
    case (r.cmd)
      CMD_INSERT: if (len_guess < CAPACITY && p >= 1 && p <= len_guess + 1) len_guess++;
      CMD_DELETE: if (p >= 1 && p <= len_guess) len_guess--;
      default: ;
    endcase
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_cmd(req_t r);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    track_length(r);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Result side: random stalls, burst stretches, one long hold-off
  initial begin : drain_results
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else if (burst)       gap = 0;
      else                  gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    phase_t ph;
    int     seg_left;
    int     seg_count;
    int     n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list errors, edge values, duplicates, head/middle/tail
    send_cmd(list_cmd(CMD_READ,   1,   32'h0));
    send_cmd(list_cmd(CMD_DELETE, 1,   32'h0));
    send_cmd(list_cmd(CMD_FIND,   1,   32'h0));
    send_cmd(list_cmd(CMD_INSERT, 0,   32'h1));
    send_cmd(list_cmd(CMD_INSERT, 2,   32'h1));
    send_cmd(list_cmd(CMD_INSERT, 127, 32'h1));
    send_cmd(list_cmd(CMD_INSERT, 1,   32'h8000_0000));
    send_cmd(list_cmd(CMD_INSERT, 2,   32'h7FFF_FFFF));
    send_cmd(list_cmd(CMD_INSERT, 1,   32'hFFFF_FFFF));
    send_cmd(list_cmd(CMD_INSERT, 2,   32'h0));
    send_cmd(list_cmd(CMD_INSERT, 5,   32'hFFFF_FFFF));
    send_cmd(list_cmd(CMD_FIND,   0,   32'hFFFF_FFFF));
    send_cmd(list_cmd(CMD_FIND,   127, 32'h7FFF_FFFF));
    send_cmd(list_cmd(CMD_FIND,   3,   32'd12345));
    send_cmd(list_cmd(CMD_READ,   1,   32'hFFFF_FFFF));
    send_cmd(list_cmd(CMD_READ,   3,   32'h0));
    send_cmd(list_cmd(CMD_READ,   5,   32'h0));
    send_cmd(list_cmd(CMD_READ,   6,   32'h0));
    send_cmd(list_cmd(CMD_READ,   0,   32'h0));
    send_cmd(list_cmd(CMD_READ,   127, 32'h0));
    send_cmd(list_cmd(CMD_DELETE, 6,   32'h0));
    send_cmd(list_cmd(CMD_DELETE, 3,   32'h0));
    send_cmd(list_cmd(CMD_DELETE, 1,   32'h0));
    send_cmd(list_cmd(CMD_DELETE, 3,   32'h0));
    send_cmd(list_cmd(CMD_READ,   2,   32'h0));

    // Random: fill to capacity, mix, drain to empty, mix, and repeat
    ph        = PH_FILL;
    seg_left  = 200;
    seg_count = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        seg_count++;
        case (seg_count % 4)
          0:       ph = PH_FILL;
          2:       ph = PH_DRAIN;
          default: ph = PH_MIX;
        endcase
        seg_left = (ph == PH_MIX) ? $urandom_range(60, 150) : $urandom_range(150, 220);
      end
      seg_left--;
      send_cmd(pick_command(ph));
    end
    req_valid <= 1'b0;

    // Let the last prediction land, then wait out the results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
